>>> rtl/sha1_pkg.sv
package sha1_pkg;

  localparam int unsigned WordW         = 32;
  localparam int unsigned ByteW         = 8;
  localparam int unsigned BytesPerWord  = 4;
  localparam int unsigned CountW        = 61;
  localparam int unsigned PosW          = 6;
  localparam int unsigned NumChain      = 5;
  localparam int unsigned NumBlockWords = 16;
  localparam int unsigned NumRounds     = 80;
  localparam int unsigned RoundsPerStep = 20;
  localparam int unsigned RoundW        = 7;
  localparam int unsigned WordIdxW      = 3;
  localparam int unsigned CfgIdxW       = 3;
  localparam int unsigned CfgDataW      = 61;
  localparam int unsigned LenWordHi     = 14;
  localparam int unsigned LenWordLo     = 15;

  localparam int unsigned ItemDepthDef   = 4;
  localparam int unsigned ResultDepthDef = 8;

  typedef logic [WordW-1:0] word_t;

  localparam logic [ByteW-1:0] PadByte = 8'h80;
  localparam logic [PosW-1:0]  LenPos  = 6'd56;

  localparam word_t K0 = 32'h5A827999;
  localparam word_t K1 = 32'h6ED9EBA1;
  localparam word_t K2 = 32'h8F1BBCDC;
  localparam word_t K3 = 32'hCA62C1D6;

  localparam word_t InitA = 32'h67452301;
  localparam word_t InitB = 32'hEFCDAB89;
  localparam word_t InitC = 32'h98BADCFE;
  localparam word_t InitD = 32'h10325476;
  localparam word_t InitE = 32'hC3D2E1F0;

  localparam logic [WordIdxW-1:0] LastWordIdx = WordIdxW'(NumChain - 1);

  typedef enum logic [CfgIdxW-1:0] {
    CFG_INIT_A     = 3'd0,
    CFG_INIT_B     = 3'd1,
    CFG_INIT_C     = 3'd2,
    CFG_INIT_D     = 3'd3,
    CFG_INIT_E     = 3'd4,
    CFG_LEN_OFFSET = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    word_t [NumChain-1:0] init;
    logic [CountW-1:0]    len_offset;
  } cfg_t;

  // bit 0: carries a byte, bit 1: closes the message
  typedef enum logic [1:0] {
    ITEM_BYTE      = 2'b01,
    ITEM_LAST      = 2'b10,
    ITEM_BYTE_LAST = 2'b11
  } item_kind_e;

  typedef struct packed {
    item_kind_e       kind;
    logic [ByteW-1:0] data;
  } item_t;

  typedef struct packed {
    word_t               word;
    logic [WordIdxW-1:0] index;
    logic                last;
  } result_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROUND,
    ST_ADD,
    ST_PAD,
    ST_LEN,
    ST_EMIT
  } state_e;

  typedef enum logic [1:0] {
    PH_DATA,
    PH_SPILL,
    PH_FINAL
  } phase_e;

endpackage

>>> rtl/sha1_fifo.sv
module sha1_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] rdata_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             push_ok, pop_ok;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rd_ptr_q];
  assign push_ok = push_i && !full_o;
  assign pop_ok  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_ok) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop_ok) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push_ok && !pop_ok) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (pop_ok && !push_ok) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

>>> rtl/sha1_front.sv
module sha1_front #(
  parameter int unsigned ItemDepth = 4
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [7:0]            data_byte_i,
  input  logic                  byte_present_i,
  input  logic                  last_item_i,
  input  logic                  push,
  output logic                  full,
  output logic                  item_valid_o,
  output sha1_pkg::item_t       item_o,
  input  logic                  item_pop_i
);

  import sha1_pkg::*;

  item_t item_in;
  logic  useful;
  logic  item_empty;

  // classify: idle items are accepted and dropped here
  always_comb begin
    item_in.data = data_byte_i;
    unique case ({last_item_i, byte_present_i})
      2'b01:   item_in.kind = ITEM_BYTE;
      2'b10:   item_in.kind = ITEM_LAST;
      2'b11:   item_in.kind = ITEM_BYTE_LAST;
      default: item_in.kind = ITEM_BYTE;
    endcase
  end

  assign useful       = byte_present_i || last_item_i;
  assign item_valid_o = !item_empty;

  sha1_fifo #(
    .Width ($bits(item_t)),
    .Depth (ItemDepth)
  ) u_item_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push && useful),
    .wdata_i (item_in),
    .full_o  (full),
    .pop_i   (item_pop_i),
    .rdata_o (item_o),
    .empty_o (item_empty)
  );

endmodule

>>> rtl/sha1_core.sv
module sha1_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  sha1_pkg::cfg_t    cfg_i,
  input  logic              item_valid_i,
  input  sha1_pkg::item_t   item_i,
  output logic              item_pop_o,
  input  logic              res_ready_i,
  output logic              res_push_o,
  output sha1_pkg::result_t res_o
);

  import sha1_pkg::*;

  localparam logic [RoundW-1:0] RoundLast = RoundW'(NumRounds - 1);
  localparam logic [RoundW-1:0] Step1     = RoundW'(RoundsPerStep);
  localparam logic [RoundW-1:0] Step2     = RoundW'(2 * RoundsPerStep);
  localparam logic [RoundW-1:0] Step3     = RoundW'(3 * RoundsPerStep);

  state_e                   state_q, state_d;
  phase_e                   phase_q, phase_d;
  logic                     last_q, last_d;
  logic                     open_q, open_d;
  logic [CountW-1:0]        count_q, count_d;
  logic [CountW-1:0]        count_inc;
  logic [RoundW-1:0]        rnd_q, rnd_d;
  logic [WordIdxW-1:0]      emit_q, emit_d;
  word_t [NumChain-1:0]     chain_q, chain_d;
  word_t [NumChain-1:0]     var_q, var_d;
  word_t [NumBlockWords-1:0] blk_q, blk_d;
  logic [CountW-1:0]        len_q, len_d;

  logic                     item_present, item_last;
  logic                     start_comp;
  logic [PosW-1:0]          pos;
  word_t                    f_val, k_val, tmp, sched;
  word_t                    a, b, c, d, e;

  assign count_inc = count_q + CountW'(1);
  assign pos       = count_q[PosW-1:0];
  assign a = var_q[0];
  assign b = var_q[1];
  assign c = var_q[2];
  assign d = var_q[3];
  assign e = var_q[4];

  always_comb begin
    unique case (item_i.kind)
      ITEM_BYTE:      begin item_present = 1'b1; item_last = 1'b0; end
      ITEM_LAST:      begin item_present = 1'b0; item_last = 1'b1; end
      ITEM_BYTE_LAST: begin item_present = 1'b1; item_last = 1'b1; end
      default:        begin item_present = 1'b0; item_last = 1'b0; end
    endcase
  end

  // round function and schedule word of the current round
  always_comb begin
    if (rnd_q < Step1) begin
      f_val = (b & c) | (~b & d);
      k_val = K0;
    end else if (rnd_q < Step2) begin
      f_val = b ^ c ^ d;
      k_val = K1;
    end else if (rnd_q < Step3) begin
      f_val = (b & c) | (b & d) | (c & d);
      k_val = K2;
    end else begin
      f_val = b ^ c ^ d;
      k_val = K3;
    end
    tmp   = {a[26:0], a[31:27]} + f_val + e + blk_q[0] + k_val;
    sched = blk_q[13] ^ blk_q[8] ^ blk_q[2] ^ blk_q[0];
    sched = {sched[30:0], sched[31]};
  end

  always_comb begin
    state_d    = state_q;
    phase_d    = phase_q;
    last_d     = last_q;
    open_d     = open_q;
    count_d    = count_q;
    rnd_d      = rnd_q;
    emit_d     = emit_q;
    chain_d    = chain_q;
    var_d      = var_q;
    blk_d      = blk_q;
    len_d      = len_q;
    start_comp = 1'b0;
    item_pop_o = 1'b0;
    res_push_o = 1'b0;
    res_o.word  = chain_q[emit_q];
    res_o.index = emit_q;
    res_o.last  = (emit_q == LastWordIdx);

    unique case (state_q)
      ST_IDLE: begin
        if (item_valid_i) begin
          item_pop_o = 1'b1;
          last_d     = item_last;
          if (!open_q) begin
            chain_d = cfg_i.init;
            open_d  = 1'b1;
          end
          if (item_present) begin
            for (int w = 0; w < NumBlockWords; w++) begin
              for (int l = 0; l < BytesPerWord; l++) begin
                if (pos == PosW'(BytesPerWord * w + l)) begin
                  blk_d[w][ByteW*(BytesPerWord-1-l) +: ByteW] = item_i.data;
                end
              end
            end
            count_d = count_inc;
            if (count_inc[PosW-1:0] == '0) begin
              start_comp = 1'b1;
              phase_d    = PH_DATA;
            end else if (item_last) begin
              state_d = ST_PAD;
            end
          end else begin
            state_d = ST_PAD;
          end
        end
      end

      ST_ROUND: begin
        var_d[0] = tmp;
        var_d[1] = a;
        var_d[2] = {b[1:0], b[31:2]};
        var_d[3] = c;
        var_d[4] = d;
        for (int i = 0; i < NumBlockWords - 1; i++) begin
          blk_d[i] = blk_q[i+1];
        end
        blk_d[NumBlockWords-1] = sched;
        rnd_d = rnd_q + RoundW'(1);
        if (rnd_q == RoundLast) begin
          rnd_d   = '0;
          state_d = ST_ADD;
        end
      end

      ST_ADD: begin
        for (int i = 0; i < NumChain; i++) begin
          chain_d[i] = chain_q[i] + var_q[i];
        end
        unique case (phase_q)
          PH_DATA:  state_d = last_q ? ST_PAD : ST_IDLE;
          PH_SPILL: state_d = ST_LEN;
          PH_FINAL: begin
            state_d = ST_EMIT;
            emit_d  = '0;
          end
          default:  state_d = ST_IDLE;
        endcase
      end

      ST_PAD: begin
        // mark byte, then zeros to the end of the block
        for (int w = 0; w < NumBlockWords; w++) begin
          for (int l = 0; l < BytesPerWord; l++) begin
            if (PosW'(BytesPerWord * w + l) == pos) begin
              blk_d[w][ByteW*(BytesPerWord-1-l) +: ByteW] = PadByte;
            end else if (PosW'(BytesPerWord * w + l) > pos) begin
              blk_d[w][ByteW*(BytesPerWord-1-l) +: ByteW] = '0;
            end
          end
        end
        len_d = cfg_i.len_offset + count_q;
        if (pos >= LenPos) begin
          start_comp = 1'b1;
          phase_d    = PH_SPILL;
        end else begin
          phase_d = PH_FINAL;
          state_d = ST_LEN;
        end
      end

      ST_LEN: begin
        // after a spill block the whole length block is fresh
        if (phase_q == PH_SPILL) begin
          for (int w = 0; w < LenWordHi; w++) begin
            blk_d[w] = '0;
          end
        end
        blk_d[LenWordHi] = len_q[CountW-1:CountW-WordW];
        blk_d[LenWordLo] = {len_q[CountW-WordW-1:0], 3'b000};
        start_comp = 1'b1;
        phase_d    = PH_FINAL;
      end

      ST_EMIT: begin
        if (res_ready_i) begin
          res_push_o = 1'b1;
          emit_d     = emit_q + WordIdxW'(1);
          if (emit_q == LastWordIdx) begin
            emit_d  = '0;
            count_d = '0;
            open_d  = 1'b0;
            state_d = ST_IDLE;
          end
        end
      end

      default: state_d = ST_IDLE;
    endcase

    if (start_comp) begin
      var_d   = chain_d;
      rnd_d   = '0;
      state_d = ST_ROUND;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      phase_q <= PH_DATA;
      last_q  <= 1'b0;
      open_q  <= 1'b0;
      count_q <= '0;
      rnd_q   <= '0;
      emit_q  <= '0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      last_q  <= last_d;
      open_q  <= open_d;
      count_q <= count_d;
      rnd_q   <= rnd_d;
      emit_q  <= emit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    chain_q <= chain_d;
    var_q   <= var_d;
    blk_q   <= blk_d;
    len_q   <= len_d;
  end

endmodule

>>> rtl/sha1_hash_engine_top.sv
// SHA-1 engine with loadable chain value and length offset. Bytes go in one per item
// through a push/full queue; an item with last_item_i set pads the message, adds the bit
// length (offset plus bytes seen, times 8) and delivers five digest words, index 0 first,
// through an empty/pop queue. Items with neither a byte nor the last mark are dropped.
// The back end takes bytes one at a time while idle; each completed 64-byte block then runs
// 80 rounds on one shared round unit plus the chain add, and no bytes are taken meanwhile;
// the front queue keeps taking bytes while the rounds run until it fills.
// The last item leads to padding, one or two blocks of rounds (a second block when fewer
// than 9 bytes remain in the current one) and then the hand-over of the five words.
// Init writes take effect at the next message; the length offset is read at padding.
module sha1_hash_engine_top #(
  parameter int unsigned ItemDepth   = sha1_pkg::ItemDepthDef,
  parameter int unsigned ResultDepth = sha1_pkg::ResultDepthDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [sha1_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [sha1_pkg::CfgDataW-1:0] cfg_wdata_i,
  input  logic [7:0]                    data_byte_i,
  input  logic                          byte_present_i,
  input  logic                          last_item_i,
  input  logic                          push,
  output logic                          full,
  output logic [31:0]                   digest_word_o,
  output logic [sha1_pkg::WordIdxW-1:0] word_index_o,
  output logic                          last_word_o,
  output logic                          empty,
  input  logic                          pop
);

  import sha1_pkg::*;

  cfg_t    cfg_q;
  item_t   item;
  logic    item_valid, item_pop;
  logic    res_push, res_full;
  result_t res_in, res_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.init[0]    <= InitA;
      cfg_q.init[1]    <= InitB;
      cfg_q.init[2]    <= InitC;
      cfg_q.init[3]    <= InitD;
      cfg_q.init[4]    <= InitE;
      cfg_q.len_offset <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_INIT_A:     cfg_q.init[0]    <= cfg_wdata_i[WordW-1:0];
        CFG_INIT_B:     cfg_q.init[1]    <= cfg_wdata_i[WordW-1:0];
        CFG_INIT_C:     cfg_q.init[2]    <= cfg_wdata_i[WordW-1:0];
        CFG_INIT_D:     cfg_q.init[3]    <= cfg_wdata_i[WordW-1:0];
        CFG_INIT_E:     cfg_q.init[4]    <= cfg_wdata_i[WordW-1:0];
        CFG_LEN_OFFSET: cfg_q.len_offset <= cfg_wdata_i[CountW-1:0];
        default:        ;
      endcase
    end
  end

  sha1_front #(
    .ItemDepth (ItemDepth)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .data_byte_i    (data_byte_i),
    .byte_present_i (byte_present_i),
    .last_item_i    (last_item_i),
    .push           (push),
    .full           (full),
    .item_valid_o   (item_valid),
    .item_o         (item),
    .item_pop_i     (item_pop)
  );

  sha1_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .item_valid_i (item_valid),
    .item_i       (item),
    .item_pop_o   (item_pop),
    .res_ready_i  (!res_full),
    .res_push_o   (res_push),
    .res_o        (res_in)
  );

  sha1_fifo #(
    .Width ($bits(result_t)),
    .Depth (ResultDepth)
  ) u_result_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .wdata_i (res_in),
    .full_o  (res_full),
    .pop_i   (pop),
    .rdata_o (res_out),
    .empty_o (empty)
  );

  assign digest_word_o = res_out.word;
  assign word_index_o  = res_out.index;
  assign last_word_o   = res_out.last;

endmodule

>>> rtl/sha1_checker.sv
module sha1_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          cfg_we_i,
  input logic [sha1_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input logic [sha1_pkg::CfgDataW-1:0] cfg_wdata_i,
  input logic [7:0]                    data_byte_i,
  input logic                          byte_present_i,
  input logic                          last_item_i,
  input logic                          push,
  input logic                          full,
  input logic [31:0]                   digest_word_o,
  input logic [sha1_pkg::WordIdxW-1:0] word_index_o,
  input logic                          last_word_o,
  input logic                          empty,
  input logic                          pop
);

  import sha1_pkg::*;

  // last flag marks exactly the final word of a digest
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (last_word_o == (word_index_o == LastWordIdx)))
    else $error("last_word_o disagrees with word_index_o");

  // words of one digest come out in index order
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && pop && !last_word_o) |=>
      (empty || word_index_o == $past(word_index_o) + WordIdxW'(1)))
    else $error("digest word index skipped");

  // a new digest starts at index zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && pop && last_word_o) |=> (empty || word_index_o == '0))
    else $error("digest does not restart at word zero");

  // a word not taken holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=>
      (!empty && $stable(digest_word_o) && $stable(word_index_o)))
    else $error("waiting digest word changed");

endmodule

bind sha1_hash_engine_top sha1_checker u_checker (.*);
